// ===== design/trilinear_force_splat_defines.svh =====
// Assertion macros shared by the trilinear force splat RTL.
`ifndef TRILINEAR_FORCE_SPLAT_DEFINES_SVH
`define TRILINEAR_FORCE_SPLAT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define TFS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define TFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tfs_pkg.sv =====
// Types and constants of the trilinear force splat block.
`default_nettype none

package tfs_pkg;

    // Fixed-point layout
    localparam int FRAC_BITS  = 12;                    // grid fraction, weights
    localparam int PROD_FRAC  = 28;                    // pos * inv_cell_size
    localparam int DROP_BITS  = PROD_FRAC - FRAC_BITS;
    localparam int GRID_MAX   = 64;
    localparam int GRID_MIN   = 2;
    localparam int NW         = 7;                     // grid size / face index width
    localparam int CW         = NW + FRAC_BITS;        // clamped coordinate width
    localparam int WW         = FRAC_BITS + 1;         // per-dimension weight width

    localparam logic [WW-1:0] ONE_F = WW'(1) << FRAC_BITS;

    // Configuration register indexes
    localparam logic [1:0] CFG_INV_CELL = 2'd0;
    localparam logic [1:0] CFG_GRID_NX  = 2'd1;
    localparam logic [1:0] CFG_GRID_NY  = 2'd2;
    localparam logic [1:0] CFG_GRID_NZ  = 2'd3;

    localparam logic [23:0]   INV_CELL_RST = 24'd65536;
    localparam logic [NW-1:0] GRID_N_RST   = NW'(32);

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    // Corner offsets {di, dj, dk} in emit order
    localparam logic [2:0] CORNER_OFF [8] = '{
        3'b000, 3'b001, 3'b010, 3'b100, 3'b110, 3'b101, 3'b011, 3'b111
    };

    localparam logic [2:0] CORNER_LAST = 3'd7;

endpackage

`default_nettype wire

// ===== design/tfs_in_if.sv =====
// Input channel: force vector and position beat.
`default_nettype none

interface tfs_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;

    modport source (output valid, force_x, force_y, force_z, pos_x, pos_y, pos_z,
                    input ready);
    modport sink   (input valid, force_x, force_y, force_z, pos_x, pos_y, pos_z,
                    output ready);
endinterface

`default_nettype wire

// ===== design/tfs_out_if.sv =====
// Output channel: one staggered-grid face write per beat.
`default_nettype none

interface tfs_out_if;
    logic                          valid;
    logic                          ready;
    tfs_pkg::t_axis                axis;
    logic [tfs_pkg::NW-1:0]        face_i;
    logic [tfs_pkg::NW-1:0]        face_j;
    logic [tfs_pkg::NW-1:0]        face_k;
    logic signed [31:0]            face_value;
    logic                          last;

    modport source (output valid, axis, face_i, face_j, face_k, face_value, last,
                    input ready);
    modport sink   (input valid, axis, face_i, face_j, face_k, face_value, last,
                    output ready);
endinterface

`default_nettype wire

// ===== design/trilinear_force_splat.sv =====
// Top level: trilinear splat of a force vector onto staggered-grid faces.
//
//  channel   dir  beat
//  i_in      in   force_x/y/z (Q16.16), pos_x/y/z (Q12.12)
//  o_out     out  axis, face_i/j/k, face_value (Q16.16), last
//  i_cfg_*   in   register index + data, one write per enabled cycle
//
// An inside position gives 24 output beats, one per cycle unless the output
// stalls; an outside one is dropped in the front end. From input beat to
// first output beat an item passes the registered stages multiply, clamp,
// sequencer, two weight multiplies, force multiply. The 24-step sequencer
// sets the rate. Synchronous active-low reset clears valid bits and sets
// config to its defaults. Every stage holds under backpressure; the front end
// takes the next item while the sequencer still expands the current one.
`default_nettype none
`include "trilinear_force_splat_defines.svh"

module trilinear_force_splat (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_idx,
    input  wire logic [23:0]      i_cfg_data,
    tfs_in_if.sink                i_in,
    tfs_out_if.source             o_out
);

    localparam int NW = tfs_pkg::NW;
    localparam int CW = tfs_pkg::CW;
    localparam int WW = tfs_pkg::WW;
    localparam int FB = tfs_pkg::FRAC_BITS;

    // ---------------- configuration ----------------
    logic [23:0]   r_inv_cell;
    logic [NW-1:0] r_grid_n [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_cell <= tfs_pkg::INV_CELL_RST;
            r_grid_n[0] <= tfs_pkg::GRID_N_RST;
            r_grid_n[1] <= tfs_pkg::GRID_N_RST;
            r_grid_n[2] <= tfs_pkg::GRID_N_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tfs_pkg::CFG_INV_CELL: r_inv_cell  <= i_cfg_data;
                tfs_pkg::CFG_GRID_NX:  r_grid_n[0] <= i_cfg_data[NW-1:0];
                tfs_pkg::CFG_GRID_NY:  r_grid_n[1] <= i_cfg_data[NW-1:0];
                tfs_pkg::CFG_GRID_NZ:  r_grid_n[2] <= i_cfg_data[NW-1:0];
                default: ;
            endcase
        end
    end

    // Effective grid size and clamp limits per dimension
    logic [NW-1:0] eff_n   [3];
    logic [CW-1:0] hi_axis [3];
    logic [CW-1:0] hi_crs  [3];

    always_comb begin
        for (int d = 0; d < 3; d++) begin
            if (r_grid_n[d] < NW'(tfs_pkg::GRID_MIN)) begin
                eff_n[d] = NW'(tfs_pkg::GRID_MIN);
            end else if (r_grid_n[d] > NW'(tfs_pkg::GRID_MAX)) begin
                eff_n[d] = NW'(tfs_pkg::GRID_MAX);
            end else begin
                eff_n[d] = r_grid_n[d];
            end
            hi_axis[d] = {eff_n[d], {FB{1'b0}}} - CW'(1);
            hi_crs[d]  = {eff_n[d] - NW'(1), {FB{1'b0}}} - CW'(1);
        end
    end

    function automatic logic [CW-1:0] clamp_coord(input logic signed [47:0] q,
                                                  input logic [CW-1:0] hi);
        logic [CW-1:0] t;
        begin
            t = q[tfs_pkg::DROP_BITS +: CW];
            if (q < 0) begin
                clamp_coord = '0;
            end else if (q[47:tfs_pkg::DROP_BITS + CW] != '0 || t > hi) begin
                clamp_coord = hi;
            end else begin
                clamp_coord = t;
            end
        end
    endfunction

    // ---------------- handshake chain ----------------
    logic r_v1, r_v2, r_in2, r_seq_v, r_vw1, r_vw2, r_vw3;
    logic ce1, ce2, seq_take, seq_issue, seq_last, ce_w1, ce_w2, ce_w3;
    tfs_pkg::t_axis r_axis;
    logic [2:0]     r_corner;

    assign ce_w3     = !r_vw3 || o_out.ready;
    assign ce_w2     = !r_vw2 || ce_w3;
    assign ce_w1     = !r_vw1 || ce_w2;
    assign seq_last  = (r_axis == tfs_pkg::AXIS_Z) && (r_corner == tfs_pkg::CORNER_LAST);
    assign seq_issue = r_seq_v && ce_w1;
    assign seq_take  = !r_seq_v || (seq_issue && seq_last);
    assign ce2       = !r_v2 || !r_in2 || seq_take;
    assign ce1       = !r_v1 || ce2;
    assign i_in.ready = ce1;

    // ---------------- stage 1: scale positions ----------------
    logic signed [47:0] r_p1 [3];
    logic signed [31:0] r_f1 [3];
    logic signed [48:0] prod [3];

    always_comb begin
        prod[0] = i_in.pos_x * $signed({1'b0, r_inv_cell});
        prod[1] = i_in.pos_y * $signed({1'b0, r_inv_cell});
        prod[2] = i_in.pos_z * $signed({1'b0, r_inv_cell});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (ce1) begin
            r_v1 <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce1) begin
            for (int d = 0; d < 3; d++) begin
                r_p1[d] <= prod[d][47:0];
            end
            r_f1[0] <= i_in.force_x;
            r_f1[1] <= i_in.force_y;
            r_f1[2] <= i_in.force_z;
        end
    end

    // ---------------- stage 2: domain test and clamp ----------------
    logic                n_in2;
    logic [CW-1:0]       n_ca [3];
    logic [CW-1:0]       n_cc [3];
    logic [CW-1:0]       r_ca2 [3];
    logic [CW-1:0]       r_cc2 [3];
    logic signed [31:0]  r_f2 [3];
    logic signed [47:0]  q_crs [3];

    always_comb begin
        n_in2 = 1'b1;
        for (int d = 0; d < 3; d++) begin
            if (r_p1[d] < 0 || r_p1[d][47:tfs_pkg::PROD_FRAC] >= 20'(eff_n[d])) begin
                n_in2 = 1'b0;
            end
            q_crs[d] = r_p1[d] - (48'sd1 <<< (tfs_pkg::PROD_FRAC - 1));
            n_ca[d]  = clamp_coord(r_p1[d], hi_axis[d]);
            n_cc[d]  = clamp_coord(q_crs[d], hi_crs[d]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2  <= 1'b0;
            r_in2 <= 1'b0;
        end else if (ce2) begin
            r_v2  <= r_v1;
            r_in2 <= n_in2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce2) begin
            r_ca2 <= n_ca;
            r_cc2 <= n_cc;
            r_f2  <= r_f1;
        end
    end

    // ---------------- sequencer: 3 axes x 8 corners ----------------
    logic [CW-1:0]      r_sq_ca [3];
    logic [CW-1:0]      r_sq_cc [3];
    logic signed [31:0] r_sq_f  [3];
    logic               seq_load;

    assign seq_load = seq_take && r_v2 && r_in2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_v  <= 1'b0;
            r_axis   <= tfs_pkg::AXIS_X;
            r_corner <= '0;
        end else begin
            if (seq_load) begin
                r_seq_v <= 1'b1;
            end else if (seq_issue && seq_last) begin
                r_seq_v <= 1'b0;
            end
            if (seq_issue) begin
                r_corner <= r_corner + 3'd1;
                if (r_corner == tfs_pkg::CORNER_LAST) begin
                    case (r_axis)
                        tfs_pkg::AXIS_X: r_axis <= tfs_pkg::AXIS_Y;
                        tfs_pkg::AXIS_Y: r_axis <= tfs_pkg::AXIS_Z;
                        default:         r_axis <= tfs_pkg::AXIS_X;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_load) begin
            r_sq_ca <= r_ca2;
            r_sq_cc <= r_cc2;
            r_sq_f  <= r_f2;
        end
    end

    // ---------------- W1: pick coordinates, first weight product ----------------
    logic [2:0]         off;
    logic [NW-1:0]      n_face [3];
    logic [WW-1:0]      wf [3];
    logic [CW-1:0]      csel;
    logic [2*WW-1:0]    r_w01;
    logic [WW-1:0]      r_wz;
    logic signed [31:0] r_fw1;
    tfs_pkg::t_axis     r_ax1;
    logic [NW-1:0]      r_face1 [3];
    logic               r_last1;

    always_comb begin
        off = tfs_pkg::CORNER_OFF[r_corner];
        for (int d = 0; d < 3; d++) begin
            csel = (r_axis == tfs_pkg::t_axis'(d)) ? r_sq_ca[d] : r_sq_cc[d];
            n_face[d] = csel[CW-1:FB] + NW'(off[2-d]);
            wf[d] = off[2-d] ? {1'b0, csel[FB-1:0]} : tfs_pkg::ONE_F - {1'b0, csel[FB-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vw1 <= 1'b0;
        end else if (ce_w1) begin
            r_vw1 <= r_seq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce_w1) begin
            r_w01   <= wf[0] * wf[1];
            r_wz    <= wf[2];
            r_fw1   <= r_sq_f[r_axis];
            r_ax1   <= r_axis;
            r_face1 <= n_face;
            r_last1 <= seq_last;
        end
    end

    // ---------------- W2: full weight, truncated to Q1.12 ----------------
    logic [3*WW-1:0]    w012;
    logic [WW-1:0]      r_w2;
    logic signed [31:0] r_fw2;
    tfs_pkg::t_axis     r_ax2;
    logic [NW-1:0]      r_face2 [3];
    logic               r_last2;

    assign w012 = r_w01 * r_wz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vw2 <= 1'b0;
        end else if (ce_w2) begin
            r_vw2 <= r_vw1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce_w2) begin
            r_w2    <= w012[2*FB +: WW];
            r_fw2   <= r_fw1;
            r_ax2   <= r_ax1;
            r_face2 <= r_face1;
            r_last2 <= r_last1;
        end
    end

    // ---------------- W3: weight times force, floor to Q16.16 ----------------
    logic signed [32+WW:0] fprod;
    logic signed [31:0]    r_val3;
    tfs_pkg::t_axis        r_ax3;
    logic [NW-1:0]         r_face3 [3];
    logic                  r_last3;

    assign fprod = r_fw2 * $signed({1'b0, r_w2});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vw3 <= 1'b0;
        end else if (ce_w3) begin
            r_vw3 <= r_vw2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce_w3) begin
            r_val3  <= fprod[FB +: 32];
            r_ax3   <= r_ax2;
            r_face3 <= r_face2;
            r_last3 <= r_last2;
        end
    end

    assign o_out.valid      = r_vw3;
    assign o_out.axis       = r_ax3;
    assign o_out.face_i     = r_face3[0];
    assign o_out.face_j     = r_face3[1];
    assign o_out.face_k     = r_face3[2];
    assign o_out.face_value = r_val3;
    assign o_out.last       = r_last3;

    // ---------------- checks ----------------
    `TFS_ASSERT_NOW(a_idle_counts, !r_seq_v, r_axis == tfs_pkg::AXIS_X && r_corner == 3'd0, "sequencer idle with nonzero count")
    `TFS_ASSERT_NEXT(a_seq_hold, r_seq_v && !ce_w1, $stable(r_axis) && $stable(r_corner) && r_seq_v, "sequencer moved while stalled")
    `TFS_ASSERT_NOW(a_last_axis, r_vw3 && r_last3, r_ax3 == tfs_pkg::AXIS_Z, "last beat not on z faces")

endmodule

`default_nettype wire
